// ===== hw/rtl/hmm_viterbi_score_step_assert.svh =====
// hmm_viterbi_score_step_assert.svh: assertion macros for the viterbi score step
// depends on nothing; included by hmm_viterbi_score_step, which checks its own logic
`ifndef HMM_VITERBI_SCORE_STEP_ASSERT_SVH
`define HMM_VITERBI_SCORE_STEP_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked outside reset
`define HVS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked at every edge, reset included
`define HVS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HVS_ASSERT(name, clk, rst, prop, msg)
`define HVS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/hvs_pkg.sv =====
// hvs_pkg: payload structs, register indexes and lane control for the viterbi score step
// depends on nothing; imported by every module of the block
`default_nettype none

package hvs_pkg;

  // packed register layout: four lanes of 16 bits
  localparam int MAX_LANES  = 4;
  localparam int LANE_W     = 16;
  localparam int CFG_DATA_W = MAX_LANES * LANE_W;
  localparam int CFG_ADDR_W = 3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANS_ROW_0    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_VECTOR = 3'd4;

  // input transaction
  typedef struct packed {
    logic              start_req;
    logic [LANE_W-1:0] emit_0;
    logic [LANE_W-1:0] emit_1;
    logic [LANE_W-1:0] emit_2;
    logic [LANE_W-1:0] emit_3;
  } hvs_in_t;

  // output transaction
  typedef struct packed {
    logic [LANE_W-1:0] score_0;
    logic [LANE_W-1:0] score_1;
    logic [LANE_W-1:0] score_2;
    logic [LANE_W-1:0] score_3;
  } hvs_out_t;

  // stage load strobes sent to every lane
  typedef struct packed {
    logic load_t;
    logic load_p;
  } hvs_lane_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hvs_lane.sv =====
// hvs_lane: one source-state lane, emit*trans then *prev for every target state
// depends on hvs_pkg for the lane control struct
`default_nettype none

module hvs_lane import hvs_pkg::*; #(
  parameter int NUM_STATES = 4,
  parameter int PROB_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire hvs_lane_ctl_t        ctl,
  input  wire logic [PROB_BITS-1:0] emit [NUM_STATES],
  input  wire logic [PROB_BITS-1:0] trans_col [NUM_STATES],
  input  wire logic [PROB_BITS-1:0] prev,
  output logic      [PROB_BITS-1:0] prod [NUM_STATES]
);

  logic [PROB_BITS-1:0]   t_q [NUM_STATES];
  logic [PROB_BITS-1:0]   t_next [NUM_STATES];
  logic [PROB_BITS-1:0]   p_next [NUM_STATES];
  logic [2*PROB_BITS-1:0] mul_t [NUM_STATES];
  logic [2*PROB_BITS-1:0] mul_p [NUM_STATES];

  // first product: emission times transition, truncated
  always_comb begin
    for (int i = 0; i < NUM_STATES; i++) begin
      mul_t[i]  = emit[i] * trans_col[i];
      t_next[i] = mul_t[i][2*PROB_BITS-1:PROB_BITS];
    end
  end

  // second product: times the previous score of this source state
  always_comb begin
    for (int i = 0; i < NUM_STATES; i++) begin
      mul_p[i]  = t_q[i] * prev;
      p_next[i] = mul_p[i][2*PROB_BITS-1:PROB_BITS];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (ctl.load_t) begin
      t_q <= t_next;
    end
    if (ctl.load_p) begin
      prod <= p_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hvs_merge.sv =====
// hvs_merge: per target state, maximum over the products of all source lanes
// depends on hvs_pkg by convention; pure logic between lane and score registers
`default_nettype none

module hvs_merge import hvs_pkg::*; #(
  parameter int NUM_STATES = 4,
  parameter int PROB_BITS  = 16
) (
  input  wire logic [PROB_BITS-1:0] prod [NUM_STATES][NUM_STATES],
  output logic      [PROB_BITS-1:0] best [NUM_STATES]
);

  // running max over at most four narrow values
  always_comb begin
    for (int i = 0; i < NUM_STATES; i++) begin
      best[i] = '0;
      for (int j = 0; j < NUM_STATES; j++) begin
        if (prod[j][i] > best[i]) begin
          best[i] = prod[j][i];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hmm_viterbi_score_step.sv =====
// hmm_viterbi_score_step: top level, config registers, lane array, merge and score store
// depends on hvs_pkg, hvs_lane, hvs_merge and hmm_viterbi_score_step_assert.svh
//
//   channel   signals                          moves
//   input     in_valid  in_ready  in_data      start flag and four emissions
//   output    out_valid out_ready out_data     four new path scores
//   config    cfg_wr_en cfg_addr  cfg_wdata    one 64-bit register write, no wait
//
// output valid rises after both stages: the emit*trans stage loads at the accept,
// the *prev stage once it is free, then the max tree writes the output register and
// the stored scores.
// a new transaction may enter the first stage while the last is in the *prev stage, which
// reads the scores the previous transaction writes back, and moves on when that stage frees.
// reset clears the config registers, the stored scores and all valid flags.
// a held output freezes the *prev stage, then the first stage, then in_ready.
`default_nettype none
`include "hmm_viterbi_score_step_assert.svh"

module hmm_viterbi_score_step import hvs_pkg::*; #(
  parameter int NUM_STATES = 4,
  parameter int PROB_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire hvs_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output hvs_out_t                   out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [PROB_BITS-1:0] trans_q [NUM_STATES][NUM_STATES];
  logic [PROB_BITS-1:0] init_q [NUM_STATES];
  logic [PROB_BITS-1:0] score_q [NUM_STATES];

  logic                 v1;
  logic                 v2;
  logic                 start_q;
  logic                 accept;
  logic                 s1_fire;
  logic                 s2_fire;
  hvs_lane_ctl_t        lane_ctl;

  logic [PROB_BITS-1:0] emit_all [MAX_LANES];
  logic [PROB_BITS-1:0] emit_v [NUM_STATES];
  logic [PROB_BITS-1:0] trans_col [NUM_STATES][NUM_STATES];
  logic [PROB_BITS-1:0] prev [NUM_STATES];
  logic [PROB_BITS-1:0] prod_all [NUM_STATES][NUM_STATES];
  logic [PROB_BITS-1:0] best [NUM_STATES];
  logic [LANE_W-1:0]    score_all [MAX_LANES];
  hvs_out_t             out_next;

  // config register writes, rows beyond the state count are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        init_q[i] <= '0;
        for (int j = 0; j < NUM_STATES; j++) begin
          trans_q[i][j] <= '0;
        end
      end
    end else if (cfg_wr_en) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        if (cfg_addr == CFG_TRANS_ROW_0 + CFG_ADDR_W'(i)) begin
          for (int j = 0; j < NUM_STATES; j++) begin
            trans_q[i][j] <= cfg_wdata[j*LANE_W +: PROB_BITS];
          end
        end
      end
      if (cfg_addr == CFG_INITIAL_VECTOR) begin
        for (int j = 0; j < NUM_STATES; j++) begin
          init_q[j] <= cfg_wdata[j*LANE_W +: PROB_BITS];
        end
      end
    end
  end

  // handshake and stage advance
  assign in_ready = !v1 || !v2;
  assign accept   = in_valid && in_ready;
  assign s1_fire  = v1 && !v2;
  assign s2_fire  = v2 && (!out_valid || out_ready);

  assign lane_ctl.load_t = accept;
  assign lane_ctl.load_p = s1_fire;

  // stage valid flags and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (s1_fire) begin
        v1 <= 1'b0;
      end
      if (s1_fire) begin
        v2 <= 1'b1;
      end else if (s2_fire) begin
        v2 <= 1'b0;
      end
      if (s2_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // start flag follows the first stage
  always_ff @(posedge clk) begin
    if (accept) begin
      start_q <= in_data.start_req;
    end
  end

  // input emissions cut to the probability width
  always_comb begin
    emit_all[0] = in_data.emit_0[PROB_BITS-1:0];
    emit_all[1] = in_data.emit_1[PROB_BITS-1:0];
    emit_all[2] = in_data.emit_2[PROB_BITS-1:0];
    emit_all[3] = in_data.emit_3[PROB_BITS-1:0];
  end

  // per lane operands: emission, transition column, previous score
  always_comb begin
    for (int j = 0; j < NUM_STATES; j++) begin
      emit_v[j] = emit_all[j];
      prev[j]   = start_q ? init_q[j] : score_q[j];
      for (int i = 0; i < NUM_STATES; i++) begin
        trans_col[j][i] = trans_q[i][j];
      end
    end
  end

  // one lane per source state
  for (genvar j = 0; j < NUM_STATES; j++) begin : g_lane
    hvs_lane #(
      .NUM_STATES (NUM_STATES),
      .PROB_BITS  (PROB_BITS)
    ) u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .emit      (emit_v),
      .trans_col (trans_col[j]),
      .prev      (prev[j]),
      .prod      (prod_all[j])
    );
  end

  // max over source lanes
  hvs_merge #(
    .NUM_STATES (NUM_STATES),
    .PROB_BITS  (PROB_BITS)
  ) u_merge (
    .prod (prod_all),
    .best (best)
  );

  // result word, states beyond the count read zero
  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      score_all[i] = '0;
    end
    for (int i = 0; i < NUM_STATES; i++) begin
      score_all[i] = LANE_W'(best[i]);
    end
    out_next.score_0 = score_all[0];
    out_next.score_1 = score_all[1];
    out_next.score_2 = score_all[2];
    out_next.score_3 = score_all[3];
  end

  // stored path scores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        score_q[i] <= '0;
      end
    end else if (s2_fire) begin
      score_q <= best;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_data <= out_next;
    end
  end

  // checks
  `HVS_ASSERT(a_score_writeback, clk, rst, s2_fire |=> (out_data.score_0 == LANE_W'(score_q[0])), "stored score differs from result")
  `HVS_ASSERT(a_out_from_stage2, clk, rst, $rose(out_valid) |-> $past(v2), "output valid without a finished stage")
  `HVS_ASSERT(a_stage2_holds, clk, rst, (v2 && !s2_fire) |=> v2, "stalled stage two dropped its transaction")
  `HVS_ASSERT(a_no_overtake, clk, rst, s1_fire |-> !s2_fire, "stage one advanced into a busy stage two")
  `HVS_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!v1 && !v2 && !out_valid), "reset left a valid flag set")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking bench for the 4-state viterbi score step (hmm_viterbi_score_step)
// depends on hvs_pkg and the rtl under hw/rtl; scores are predicted in-bench and checked
// in order, with random idling on both channels and one long output stall
`timescale 1ns / 100ps

module tb;
  import hvs_pkg::*;

  // register indexes not given by the package
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = CFG_INITIAL_VECTOR + 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = '1;

  localparam int RAND_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int STALL_AT_RESULT = 160;
  localparam int STALL_CYCLES    = 120;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;
  typedef enum int {MODEL_MAX, MODEL_HIGH, MODEL_RANDOM, MODEL_ZERO, MODEL_SPARSE} model_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    hvs_in_t               item;
    bit                    has_want;
    hvs_out_t              want;
  } step_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid;
  logic                  in_ready;
  hvs_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  hvs_out_t              out_data;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor copy of the registers and the stored path scores
  logic [CFG_DATA_W-1:0] trans_cfg [MAX_LANES];
  logic [CFG_DATA_W-1:0] prior_cfg;
  logic [LANE_W-1:0]     path_score [MAX_LANES];

  hvs_out_t  pending_scores [$];
  step_row_t directed [$];
  int        mismatches = 0;
  bit        send_fast = 1'b0;
  bit        recv_fast = 1'b0;

  hmm_viterbi_score_step dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_wr_en, .cfg_addr, .cfg_wdata
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // max-product step: best over sources of truncated emit*trans*prev, updates path_score
  function automatic hvs_out_t next_path_scores(hvs_in_t it);
    logic [LANE_W-1:0]   emit [MAX_LANES];
    logic [LANE_W-1:0]   prev [MAX_LANES];
    logic [LANE_W-1:0]   best [MAX_LANES];
    logic [2*LANE_W-1:0] prod;
    logic [LANE_W-1:0]   tp;
    emit = '{it.emit_0, it.emit_1, it.emit_2, it.emit_3};
    for (int j = 0; j < MAX_LANES; j++)
      prev[j] = it.start_req ? prior_cfg[LANE_W*j +: LANE_W] : path_score[j];
    for (int i = 0; i < MAX_LANES; i++) begin
      best[i] = '0;
      for (int j = 0; j < MAX_LANES; j++) begin
        prod = emit[i] * trans_cfg[i][LANE_W*j +: LANE_W];
        tp = prod[2*LANE_W-1:LANE_W];
        prod = tp * prev[j];
        if (prod[2*LANE_W-1:LANE_W] > best[i])
          best[i] = prod[2*LANE_W-1:LANE_W];
      end
    end
    path_score = best;
    return hvs_out_t'{best[0], best[1], best[2], best[3]};
  endfunction

  function automatic int idle_cycles(bit fast);
    return fast ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [LANE_W-1:0] draw_emit(bit high_bias);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (high_bias && r < 12) return LANE_W'($urandom_range(16'hC000, 16'hFFFF));
    return LANE_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] model_word(model_kind_e kind);
    logic [CFG_DATA_W-1:0] w;
    for (int k = 0; k < MAX_LANES; k++) begin
      case (kind)
        MODEL_MAX:    w[LANE_W*k +: LANE_W] = '1;
        MODEL_ZERO:   w[LANE_W*k +: LANE_W] = '0;
        MODEL_HIGH:   w[LANE_W*k +: LANE_W] = LANE_W'($urandom_range(16'hC000, 16'hFFFF));
        MODEL_SPARSE: w[LANE_W*k +: LANE_W] = $urandom_range(0, 1) ? '0 :
                                              LANE_W'($urandom_range(16'h8000, 16'hFFFF));
        default:      w[LANE_W*k +: LANE_W] = LANE_W'($urandom);
      endcase
    end
    return w;
  endfunction

  // directed table rows
  function automatic void row_item(bit s, logic [LANE_W-1:0] e0, logic [LANE_W-1:0] e1,
                                   logic [LANE_W-1:0] e2, logic [LANE_W-1:0] e3);
    directed.push_back('{ROW_ITEM, '0, '0, hvs_in_t'{s, e0, e1, e2, e3}, 1'b0, '0});
  endfunction

  function automatic void row_check(bit s, logic [LANE_W-1:0] e0, logic [LANE_W-1:0] e1,
                                    logic [LANE_W-1:0] e2, logic [LANE_W-1:0] e3,
                                    logic [LANE_W-1:0] want_all);
    directed.push_back('{ROW_ITEM, '0, '0, hvs_in_t'{s, e0, e1, e2, e3}, 1'b1,
                         hvs_out_t'{want_all, want_all, want_all, want_all}});
  endfunction

  function automatic void row_write(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    directed.push_back('{ROW_WRITE, a, d, '0, 1'b0, '0});
  endfunction

  // compare one output transaction against the oldest pending expectation
  function automatic void check_scores(hvs_out_t got);
    hvs_out_t want;
    bit       stray;
    stray = (pending_scores.size() == 0);
    want = stray ? '0 : pending_scores.pop_front();
    if (stray || got.score_0 !== want.score_0 || got.score_1 !== want.score_1 ||
        got.score_2 !== want.score_2 || got.score_3 !== want.score_3) begin
      mismatches++;
      if (mismatches <= 10)
        $display("score mismatch%s: want %h %h %h %h got %h %h %h %h",
                 stray ? " (nothing pending)" : "",
                 want.score_0, want.score_1, want.score_2, want.score_3,
                 got.score_0, got.score_1, got.score_2, got.score_3);
    end
  endfunction

  // offer one input transaction, predict on accept
  task automatic offer(input hvs_in_t it, input bit has_want, input hvs_out_t want);
    int       gap;
    hvs_out_t pred;
    gap = idle_cycles(send_fast);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = next_path_scores(it);
    pending_scores.push_back(has_want ? want : pred);
  endtask

  // block is idle once every score is back and the pipeline has had time to empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    if (a < CFG_INITIAL_VECTOR)
      trans_cfg[a - CFG_TRANS_ROW_0] = d;
    else if (a == CFG_INITIAL_VECTOR)
      prior_cfg = d;
    @(posedge clk);
  endtask

  task automatic load_model(input model_kind_e kind);
    logic [CFG_ADDR_W-1:0] row_addr;
    wait_idle();
    for (int r = 0; r < MAX_LANES; r++) begin
      row_addr = CFG_TRANS_ROW_0 + CFG_ADDR_W'(r);
      write_reg(row_addr, model_word(kind));
    end
    write_reg(CFG_INITIAL_VECTOR, model_word(kind));
    write_reg(CFG_SPARE_LO, {$urandom, $urandom});
    write_reg(CFG_SPARE_HI, {$urandom, $urandom});
    cfg_wr_en <= 1'b0;
  endtask

  // output side: random backpressure plus one long hold-off
  initial begin
    int gap;
    int rx_count;
    rx_count = 0;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_fast = !recv_fast;
      gap = idle_cycles(recv_fast);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_scores(out_data);
      rx_count++;
      // long stall so the pipeline fills and in_ready drops
      if (rx_count == STALL_AT_RESULT) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
    end
  end

  // input side: directed table, then random phases under several register settings
  initial begin
    hvs_in_t it;
    bit      writing;
    bit      high_bias;
    int      sent;
    int      len;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    prior_cfg = '0;
    for (int k = 0; k < MAX_LANES; k++) begin
      trans_cfg[k]  = '0;
      path_score[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: every score is zero
    row_check(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    row_check(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    // everything at full scale, spare indexes written with zero must change nothing
    row_write(CFG_TRANS_ROW_0,         '1);
    row_write(CFG_TRANS_ROW_0 + 3'd1,  '1);
    row_write(CFG_TRANS_ROW_0 + 3'd2,  '1);
    row_write(CFG_TRANS_ROW_0 + 3'd3,  '1);
    row_write(CFG_INITIAL_VECTOR,      '1);
    row_write(CFG_SPARE_LO,            '0);
    row_write(CFG_SPARE_HI,            '0);
    // no start yet: stored scores are still zero
    row_check(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    row_check(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFD);
    row_item (1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    row_check(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    row_check(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    row_check(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    row_item (1'b1, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001);
    row_item (1'b0, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000);
    // uneven rows so the winning source differs per state
    row_write(CFG_TRANS_ROW_0,        64'h8000_0100_F000_1000);
    row_write(CFG_TRANS_ROW_0 + 3'd1, 64'h0001_FFFF_0000_7FFF);
    row_write(CFG_TRANS_ROW_0 + 3'd2, 64'hAAAA_5555_C000_0400);
    row_write(CFG_TRANS_ROW_0 + 3'd3, 64'h0000_0000_0000_FFFF);
    row_write(CFG_INITIAL_VECTOR,     64'h4000_C000_2000_FFFF);
    row_item (1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    row_item (1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    row_item (1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    row_item (1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    row_item (1'b1, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE);
    row_item (1'b0, 16'hC000, 16'hC000, 16'hC000, 16'hC000);
    row_item (1'b1, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    // zero transitions wipe every path whatever the prior
    row_write(CFG_TRANS_ROW_0,        '0);
    row_write(CFG_TRANS_ROW_0 + 3'd1, '0);
    row_write(CFG_TRANS_ROW_0 + 3'd2, '0);
    row_write(CFG_TRANS_ROW_0 + 3'd3, '0);
    row_write(CFG_INITIAL_VECTOR,     '1);
    row_check(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    row_check(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);

    writing = 1'b0;
    foreach (directed[n]) begin
      if (directed[n].kind == ROW_WRITE) begin
        if (!writing) begin
          wait_idle();
          writing = 1'b1;
        end
        write_reg(directed[n].addr, directed[n].wdata);
      end else begin
        if (writing) begin
          cfg_wr_en <= 1'b0;
          writing = 1'b0;
        end
        offer(directed[n].item, directed[n].has_want, directed[n].want);
      end
    end

    // random phases: mostly start-led sequences, some loose transactions
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_model(model_kind_e'(ph % 5));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 7) == 0) send_fast = !send_fast;
        if ($urandom_range(0, 99) < 15) begin
          it = {1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
          offer(it, 1'b0, '0);
          sent++;
        end else begin
          high_bias = ($urandom_range(0, 9) < 7);
          len = $urandom_range(1, 12);
          it = hvs_in_t'{1'b1, draw_emit(high_bias), draw_emit(high_bias),
                         draw_emit(high_bias), draw_emit(high_bias)};
          offer(it, 1'b0, '0);
          for (int k = 0; k < len; k++) begin
            it = hvs_in_t'{1'b0, draw_emit(high_bias), draw_emit(high_bias),
                           draw_emit(high_bias), draw_emit(high_bias)};
            offer(it, 1'b0, '0);
          end
          sent += len + 1;
        end
      end
    end

    // drain, then leave room for any stray output
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_scores.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
